// File: sv/rebe_pkg.sv
// Package for the rotary encoder button events unit: event codes, register
// indexes, reset values, sequencer states and the button evaluation struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rebe_pkg;

	typedef enum logic [1:0] {
		EV_CW    = 2'd0,
		EV_CCW   = 2'd1,
		EV_HOLD  = 2'd2,
		EV_CLICK = 2'd3
	} event_code_t;

	typedef enum logic [1:0] {
		CFG_STEPS_PER_DETENT = 2'd0,
		CFG_DEBOUNCE_MS      = 2'd1,
		CFG_HOLD_MS          = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RUN,
		ST_BTN
	} state_t;

	localparam int          CFG_DATA_W        = 16;
	localparam logic [2:0]  STEPS_RESET       = 3'd2;
	localparam logic [15:0] DEBOUNCE_RESET    = 16'd15;
	localparam logic [15:0] HOLD_RESET        = 16'd600;
	localparam logic [15:0] PRESS_MAX         = 16'hFFFF;

	typedef struct packed {
		logic [15:0] press_next;
		logic        hold_next;
		logic        pend;
		event_code_t code;
	} btn_eval_t;

endpackage
`default_nettype wire

// File: sv/rebe_in_if.sv
// Input channel of the rotary encoder button events unit: one poll item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface rebe_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] encoder_count;
	logic        [15:0] interval_ms;
	logic               button_pressed;

	modport source (output valid, output encoder_count, output interval_ms,
		output button_pressed, input ready);
	modport sink (input valid, input encoder_count, input interval_ms,
		input button_pressed, output ready);
endinterface
`default_nettype wire

// File: sv/rebe_out_if.sv
// Output channel of the rotary encoder button events unit: one event.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface rebe_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;
	logic       last_event;

	modport source (output valid, output event_code, output last_event, input ready);
	modport sink (input valid, input event_code, input last_event, output ready);
endinterface
`default_nettype wire

// File: sv/rotary_encoder_button_events_unit.sv
// Rotary encoder detent and push-button event unit.
// Poll items arrive on enc_in; events leave on evt_out, each poll's last
// event flagged by last_event. A poll is taken only while the sequencer is
// idle: it is registered, then the counter difference and the button decision
// are formed, then detent events (at most MAX_DETENTS_PER_ITEM) go out in turn
// through a shared add/compare unit, then a hold or click event if any.
// Events pass through a single output register; while the receiver holds ready
// low the sequencer waits and nothing is lost. Leftover detent steps stay in
// the reference count for later polls.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the
// next edge and belong only to idle periods. Reset (arst_n low) restores
// steps_per_detent 2, debounce_ms 15, hold_ms 600 and clears the reference
// count, press time and hold flag; the block is ready right after reset.
// Depends on rebe_pkg, rebe_in_if, rebe_out_if, rebe_button.
`timescale 1ns / 1ps
`default_nettype none
module rotary_encoder_button_events_unit #(
	parameter int MAX_DETENTS_PER_ITEM = 63
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	rebe_in_if.sink                            enc_in,
	rebe_out_if.source                         evt_out,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [rebe_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rebe_pkg::*;

	localparam int CNT_W = $clog2(MAX_DETENTS_PER_ITEM + 1);

	state_t state_q, state_d;

	logic [2:0]         steps_q;
	logic [15:0]        debounce_q, hold_q;
	logic [15:0]        ref_q, press_q;
	logic               hold_sent_q;

	logic signed [15:0] count_q;
	logic [15:0]        elapsed_q;
	logic               pressed_q;

	logic signed [15:0] delta_q;
	logic               dir_q;
	logic [CNT_W-1:0]   det_q;
	logic               btn_pend_q;
	event_code_t        btn_code_q;

	logic               out_valid_q;
	event_code_t        out_code_q;
	logic               out_last_q;

	btn_eval_t          btn;
	logic [2:0]         step;
	logic signed [16:0] step17;
	logic [15:0]        diff;
	logic signed [15:0] delta_new;
	logic [15:0]        ref_new;
	logic [CNT_W-1:0]   det_next;
	logic               more, next_more, out_free;
	logic               take, do_eval, emit_det, emit_btn;

	function automatic logic detent_left(input logic signed [15:0] d,
		input logic dir, input logic signed [16:0] s);
		logic signed [16:0] d17;
		d17 = {d[15], d};
		detent_left = dir ? (d17 <= -s) : (d17 >= s);
	endfunction

	rebe_button u_button (
		.press_time     (press_q),
		.hold_sent      (hold_sent_q),
		.interval_ms    (elapsed_q),
		.button_pressed (pressed_q),
		.debounce_ms    (debounce_q),
		.hold_ms        (hold_q),
		.result         (btn)
	);

	always_comb begin
		step      = (steps_q == 3'd0) ? 3'd1 : steps_q;
		step17    = signed'({14'd0, step});
		diff      = count_q - ref_q;
		// shared unit: one step of the remaining difference and the reference
		delta_new = dir_q ? (delta_q + signed'({13'd0, step}))
			: (delta_q - signed'({13'd0, step}));
		ref_new   = dir_q ? (ref_q - {13'd0, step}) : (ref_q + {13'd0, step});
		det_next  = det_q + CNT_W'(1);
		more      = detent_left(delta_q, dir_q, step17)
			&& (det_q < CNT_W'(MAX_DETENTS_PER_ITEM));
		next_more = detent_left(delta_new, dir_q, step17)
			&& (det_next < CNT_W'(MAX_DETENTS_PER_ITEM));
		out_free  = !out_valid_q || evt_out.ready;
	end

	always_comb begin
		state_d  = state_q;
		take     = 1'b0;
		do_eval  = 1'b0;
		emit_det = 1'b0;
		emit_btn = 1'b0;
		case (state_q)
			ST_IDLE: begin
				take = enc_in.valid;
				if (enc_in.valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				do_eval = 1'b1;
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (more) begin
					if (out_free) emit_det = 1'b1;
				end else if (btn_pend_q) begin
					state_d = ST_BTN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_BTN: begin
				if (out_free) begin
					emit_btn = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign enc_in.ready       = (state_q == ST_IDLE);
	assign evt_out.valid      = out_valid_q;
	assign evt_out.event_code = out_code_q;
	assign evt_out.last_event = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q    <= STEPS_RESET;
			debounce_q <= DEBOUNCE_RESET;
			hold_q     <= HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEPS_PER_DETENT: steps_q    <= cfg_wdata[2:0];
				CFG_DEBOUNCE_MS:      debounce_q <= cfg_wdata;
				CFG_HOLD_MS:          hold_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q       <= '0;
			press_q     <= '0;
			hold_sent_q <= 1'b0;
			btn_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_eval) begin
				press_q     <= btn.press_next;
				hold_sent_q <= btn.hold_next;
				btn_pend_q  <= btn.pend;
			end
			if (emit_det) ref_q <= ref_new;
			if (emit_btn) btn_pend_q <= 1'b0;
			if (emit_det || emit_btn) begin
				out_valid_q <= 1'b1;
			end else if (evt_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			count_q   <= enc_in.encoder_count;
			elapsed_q <= enc_in.interval_ms;
			pressed_q <= enc_in.button_pressed;
		end
		if (do_eval) begin
			delta_q    <= signed'(diff);
			dir_q      <= diff[15];
			det_q      <= '0;
			btn_code_q <= btn.code;
		end
		if (emit_det) begin
			delta_q    <= delta_new;
			det_q      <= det_next;
			out_code_q <= dir_q ? EV_CCW : EV_CW;
			out_last_q <= !next_more && !btn_pend_q;
		end
		if (emit_btn) begin
			out_code_q <= btn_code_q;
			out_last_q <= 1'b1;
		end
	end
endmodule
`default_nettype wire

// File: sv/rebe_button.sv
// Button press timing: accumulates press time, decides hold or click.
// Depends on rebe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rebe_button (
	input  wire logic [15:0]         press_time,
	input  wire logic                hold_sent,
	input  wire logic [15:0]         interval_ms,
	input  wire logic                button_pressed,
	input  wire logic [15:0]         debounce_ms,
	input  wire logic [15:0]         hold_ms,
	output rebe_pkg::btn_eval_t      result
);
	import rebe_pkg::*;

	logic [15:0] elapsed_eff;
	logic [16:0] sum;
	logic [15:0] sat;

	always_comb begin
		// a zero interval counts as one millisecond
		elapsed_eff = (interval_ms == 16'd0) ? 16'd1 : interval_ms;
		sum         = {1'b0, press_time} + {1'b0, elapsed_eff};
		sat         = sum[16] ? PRESS_MAX : sum[15:0];
		result      = '0;
		result.code = EV_HOLD;
		if (button_pressed) begin
			result.press_next = sat;
			result.hold_next  = hold_sent;
			if ((sat >= hold_ms) && !hold_sent) begin
				result.hold_next = 1'b1;
				result.pend      = 1'b1;
			end
		end else begin
			result.press_next = 16'd0;
			result.hold_next  = 1'b0;
			result.code       = EV_CLICK;
			result.pend       = (press_time != 16'd0) && (press_time >= debounce_ms)
				&& !hold_sent;
		end
	end
endmodule
`default_nettype wire

// File: tb/tb_rotary_encoder_button_events_unit.sv
// Testbench for rotary_encoder_button_events_unit: drives encoder/button polls
// and compares every detent, hold and click event against an in-bench predictor.
// Depends on rebe_pkg, rebe_in_if, rebe_out_if and the unit itself.
`timescale 1ns / 1ps
module tb_rotary_encoder_button_events_unit;
	import rebe_pkg::*;

	localparam int MAX_DETENTS = 63;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		event_code_t code;
		logic        is_last;
	} knob_event_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rebe_in_if  enc_ch();
	rebe_out_if evt_ch();

	rotary_encoder_button_events_unit #(
		.MAX_DETENTS_PER_ITEM(MAX_DETENTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.enc_in(enc_ch),
		.evt_out(evt_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor copy of the configuration and state
	logic [2:0]  cfg_steps = STEPS_RESET;
	logic [15:0] cfg_debounce = DEBOUNCE_RESET;
	logic [15:0] cfg_hold = HOLD_RESET;
	logic [15:0] knob_ref = '0;
	logic [15:0] press_acc = '0;
	logic        hold_reported = 1'b0;

	knob_event_t pending_events[$];
	int mismatch_count = 0;
	bit src_gaps = 1'b1;
	bit sink_gaps = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Work out the events one poll causes and queue them in order.
	task automatic predict_poll(input logic [15:0] count, input logic [15:0] elapsed,
		input logic pressed);
		int step;
		int delta;
		int turns;
		logic [15:0] diff;
		logic [15:0] ms;
		logic [16:0] sum;
		event_code_t evs[$];
		step = (cfg_steps == 3'd0) ? 1 : int'(cfg_steps);
		diff = count - knob_ref;
		delta = int'($signed(diff));
		ms = (elapsed == 16'd0) ? 16'd1 : elapsed;
		turns = 0;
		while (delta >= step && turns < MAX_DETENTS) begin
			evs.push_back(EV_CW);
			delta -= step;
			knob_ref = knob_ref + 16'(step);
			turns++;
		end
		while (delta <= -step && turns < MAX_DETENTS) begin
			evs.push_back(EV_CCW);
			delta += step;
			knob_ref = knob_ref - 16'(step);
			turns++;
		end
		if (pressed) begin
			sum = {1'b0, press_acc} + {1'b0, ms};
			press_acc = sum[16] ? PRESS_MAX : sum[15:0];
			if (press_acc >= cfg_hold && !hold_reported) begin
				hold_reported = 1'b1;
				evs.push_back(EV_HOLD);
			end
		end else begin
			// a button-up poll with no press time is not a release
			if (press_acc != 16'd0 && press_acc >= cfg_debounce && !hold_reported)
				evs.push_back(EV_CLICK);
			press_acc = '0;
			hold_reported = 1'b0;
		end
		foreach (evs[i])
			pending_events.push_back('{code: evs[i], is_last: (i == evs.size() - 1)});
	endtask

	// Enter just after a rising edge; return just after the accepting edge.
	task automatic send_poll(input logic [15:0] count, input logic [15:0] elapsed,
		input logic pressed);
		while (src_gaps && $urandom_range(0, 99) < 37) begin
			@(negedge clk);
			enc_ch.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		enc_ch.valid <= 1'b1;
		enc_ch.encoder_count <= count;
		enc_ch.interval_ms <= elapsed;
		enc_ch.button_pressed <= pressed;
		do @(posedge clk); while (!enc_ch.ready);
		predict_poll(count, elapsed, pressed);
	endtask

	// Drop valid, wait for every queued event, then let the sequencer finish.
	task automatic settle_idle();
		@(negedge clk);
		enc_ch.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_STEPS_PER_DETENT: cfg_steps = data[2:0];
			CFG_DEBOUNCE_MS:      cfg_debounce = data;
			CFG_HOLD_MS:          cfg_hold = data;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] steps, input logic [15:0] debounce,
		input logic [15:0] hold);
		settle_idle();
		write_reg(CFG_STEPS_PER_DETENT, steps);
		write_reg(CFG_DEBOUNCE_MS, debounce);
		write_reg(CFG_HOLD_MS, hold);
		@(posedge clk);
	endtask

	// Reset values: step 2, debounce 15, hold 600.
	task automatic test_power_on_defaults();
		send_poll(16'd5, 16'd0, 1'b0);
		send_poll(16'h8000, 16'hFFFF, 1'b1);
		send_poll(16'h8000, 16'd1, 1'b1);
		send_poll(16'd0, 16'd0, 1'b0);
		send_poll(16'h7FFF, 16'd10, 1'b1);
		send_poll(16'h7FFF, 16'd4, 1'b0);
		send_poll(16'h7FFF, 16'd15, 1'b1);
		send_poll(16'h7FFF, 16'd0, 1'b0);
	endtask

	task automatic test_detent_limits();
		apply_settings(16'd1, 16'd15, 16'd600);
		send_poll(knob_ref + 16'd100, 16'd1, 1'b0);
		send_poll(knob_ref, 16'd1, 1'b0);
		send_poll(16'h7FFF, 16'd1, 1'b0);
		send_poll(16'h8000, 16'd1, 1'b0);
		send_poll(16'h7FFF, 16'd1, 1'b0);
		apply_settings(16'd7, 16'd15, 16'd600);
		send_poll(knob_ref + 16'd6, 16'd1, 1'b0);
		send_poll(knob_ref + 16'd7, 16'd1, 1'b0);
		send_poll(knob_ref - 16'd20, 16'd1, 1'b0);
	endtask

	task automatic test_button_timing();
		apply_settings(16'd0, 16'd0, 16'd0);
		send_poll(knob_ref, 16'd5, 1'b1);
		send_poll(knob_ref, 16'd5, 1'b0);
		send_poll(knob_ref + 16'd1, 16'd0, 1'b0);
		apply_settings(16'd3, 16'd0, 16'hFFFF);
		send_poll(knob_ref, 16'd1, 1'b1);
		send_poll(knob_ref, 16'd1, 1'b0);
		send_poll(knob_ref, 16'hFFFF, 1'b1);
		send_poll(knob_ref, 16'hFFFF, 1'b1);
		send_poll(knob_ref, 16'd3, 1'b0);
	endtask

	task automatic test_random_polls();
		logic [15:0] dial;
		logic [15:0] ms;
		logic btn;
		int r;
		dial = knob_ref;
		btn = 1'b0;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: apply_settings(16'd1, 16'd0, 16'd1);
				1: apply_settings(16'd4, 16'd15, 16'd600);
				2: apply_settings(16'd7, 16'hFFFF, 16'hFFFF);
				3: apply_settings(16'd0, 16'($urandom_range(0, 1000)),
					16'($urandom_range(1, 2000)));
				// junk above the three step bits
				4: apply_settings({13'($urandom), 3'($urandom_range(1, 3))},
					16'($urandom_range(0, 1000)), 16'($urandom_range(1, 2000)));
				default: apply_settings(16'd2, 16'd15, 16'd600);
			endcase
			// first phase runs with no idling on either side
			src_gaps = (phase != 0);
			sink_gaps = (phase != 0);
			for (int n = 0; n < 73; n++) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					dial = dial + 16'($urandom_range(0, 18)) - 16'd9;
				else if (r < 85)
					dial = dial + 16'($urandom_range(0, 400)) - 16'd200;
				else
					dial = 16'($urandom);
				r = $urandom_range(0, 99);
				if (r < 60)
					ms = 16'($urandom_range(1, 40));
				else if (r < 70)
					ms = 16'd0;
				else if (r < 80)
					ms = 16'hFFFF;
				else
					ms = 16'($urandom_range(0, 65535));
				if ($urandom_range(0, 99) < 20)
					btn = !btn;
				send_poll(dial, ms, btn);
			end
		end
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
	endtask

	always @(negedge clk)
		evt_ch.ready <= !sink_gaps || ($urandom_range(0, 99) >= 37);

	always @(posedge clk) begin : check_events
		knob_event_t want;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event code %0d last %0b",
					evt_ch.event_code, evt_ch.last_event));
			end else begin
				want = pending_events.pop_front();
				if (evt_ch.event_code !== want.code)
					report_mismatch($sformatf("event_code %0d, want %0d",
						evt_ch.event_code, want.code));
				if (evt_ch.last_event !== want.is_last)
					report_mismatch($sformatf("last_event %0b, want %0b",
						evt_ch.last_event, want.is_last));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		enc_ch.valid = 1'b0;
		enc_ch.encoder_count = '0;
		enc_ch.interval_ms = '0;
		enc_ch.button_pressed = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_defaults();
		test_detent_limits();
		test_button_timing();
		test_random_polls();
		settle_idle();
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end
endmodule
